/* hdl/sdtp_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the
// sorted deadline timer pool. No dependencies.
`default_nettype none
package sdtp_pkg;

    localparam int TIMER_SLOTS_DEF = 32;
    localparam int MAX_RES         = 32;

    // Input item kinds
    localparam logic [2:0] KIND_TICK  = 3'd0;
    localparam logic [2:0] KIND_ALLOC = 3'd1;
    localparam logic [2:0] KIND_FREE  = 3'd2;
    localparam logic [2:0] KIND_INIT  = 3'd3;
    localparam logic [2:0] KIND_SET   = 3'd4;

    // Result kinds
    localparam logic [1:0] RK_ACK    = 2'd0;
    localparam logic [1:0] RK_EXPIRY = 2'd1;
    localparam logic [1:0] RK_NOFREE = 2'd2;
    localparam logic [1:0] RK_ACTIVE = 2'd3;

    // Slot status
    localparam logic [1:0] ST_FREE   = 2'd0;
    localparam logic [1:0] ST_ALLOC  = 2'd1;
    localparam logic [1:0] ST_ACTIVE = 2'd2;

    // Link RAM read address select
    localparam logic [1:0] RA_HEAD = 2'd0;
    localparam logic [1:0] RA_SLOT = 2'd1;
    localparam logic [1:0] RA_PREV = 2'd2;

    // Link RAM write address / data select
    localparam logic WA_SLOT = 1'b0;
    localparam logic WA_PREV = 1'b1;
    localparam logic [1:0] WD_HEAD = 2'd0;
    localparam logic [1:0] WD_SLOT = 2'd1;
    localparam logic [1:0] WD_CUR  = 2'd2;
    localparam logic [1:0] WD_NXQ  = 2'd3;

    // Head, earliest-deadline and previous-pointer update selects
    localparam logic [1:0] H_KEEP = 2'd0;
    localparam logic [1:0] H_NXQ  = 2'd1;
    localparam logic [1:0] H_SLOT = 2'd2;
    localparam logic [1:0] E_KEEP = 2'd0;
    localparam logic [1:0] E_DLQ  = 2'd1;
    localparam logic [1:0] E_DL   = 2'd2;
    localparam logic [1:0] P_KEEP = 2'd0;
    localparam logic [1:0] P_HEAD = 2'd1;
    localparam logic [1:0] P_NXQ  = 2'd2;
    localparam logic [1:0] P_CUR  = 2'd3;

    typedef struct packed {
        logic       load;
        logic       tick;
        logic       ptr_clr;
        logic       ptr_inc;
        logic       st_wr;
        logic [1:0] st_val;
        logic       rk_ld;
        logic [1:0] rk_val;
        logic       rslot_ptr;
        logic       init_wr;
        logic       set_dl;
        logic       nx_rd;
        logic [1:0] nx_ra;
        logic       nx_wr;
        logic       nx_wa;
        logic [1:0] nx_wd;
        logic       pd_rd;
        logic       dl_rd;
        logic [1:0] head_sel;
        logic [1:0] earl_sel;
        logic [1:0] prev_sel;
        logic       cur_ld;
        logic       cur_clr;
        logic       cnt_clr;
        logic       cnt_inc;
        logic       emit_ack;
        logic       emit_pop;
    } cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       inpool;
        logic       slot_zero;
        logic       st_free;
        logic       st_active;
        logic       ptr_last;
        logic       head_zero;
        logic       due;
        logic       head_is_slot;
        logic       nx_is_slot;
        logic       nx_zero;
        logic       cnt_last;
        logic       dl_le_earl;
        logic       dl_le_q;
        logic       cur_zero;
        logic       out_free;
        logic       pop_last;
    } stat_t;

endpackage
`default_nettype wire

/* hdl/sorted_deadline_timer_pool.sv */
// Pool of timers kept as a linked list sorted by deadline, with a sentinel
// in slot 0. An item may walk the list: a tick pops expired timers off
// the head, a set passes entries in the link RAM to find its place, a free
// passes entries to find the predecessor, and an allocate scans the status
// flags slot by slot. The walk speed is set by the registered reads of the
// link and deadline RAMs. Results are held in an output register; a new
// item is taken only when the previous one has finished its walk.
//
// Top level; depends on sdtp_pkg, sdtp_ctrl, sdtp_dp and sdtp_ram.
`default_nettype none
module sorted_deadline_timer_pool #(
    parameter int TIMER_SLOTS = sdtp_pkg::TIMER_SLOTS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [4:0]  cfg_wdata,   // switch_slot
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,     // slot[4:0], delay, payload, destination
    input  wire logic [2:0]  s_tuser,     // kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,     // slot_res[4:0], payload_res, destination_res
    output logic [2:0]       m_tuser,     // result_kind[1:0], switch_req
    output logic             m_tlast      // last
);

    sdtp_pkg::cmd_t  cmd;
    sdtp_pkg::stat_t stat;

    sdtp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sdtp_dp #(.TIMER_SLOTS(TIMER_SLOTS)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
`default_nettype wire

/* hdl/sdtp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sdtp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port, registered read port that holds when not enabled
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

/* hdl/sdtp_ctrl.sv */
// Controller of the timer pool: sequences list walks, scans and result
// transfers. Depends on sdtp_pkg.
`default_nettype none
module sdtp_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire sdtp_pkg::stat_t stat,
    output sdtp_pkg::cmd_t     cmd
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DECODE   = 5'd1;
    localparam logic [4:0] S_ACK      = 5'd2;
    localparam logic [4:0] S_TCHK     = 5'd3;
    localparam logic [4:0] S_POP_RD   = 5'd4;
    localparam logic [4:0] S_POP_NX   = 5'd5;
    localparam logic [4:0] S_POP_EM   = 5'd6;
    localparam logic [4:0] S_SCAN     = 5'd7;
    localparam logic [4:0] S_UNL_ST   = 5'd8;
    localparam logic [4:0] S_UNL_H1   = 5'd9;
    localparam logic [4:0] S_UNL_H2   = 5'd10;
    localparam logic [4:0] S_UNL_RD   = 5'd11;
    localparam logic [4:0] S_UNL_CHK  = 5'd12;
    localparam logic [4:0] S_UNL_LINK = 5'd13;
    localparam logic [4:0] S_INS_ST   = 5'd14;
    localparam logic [4:0] S_INS_RD   = 5'd15;
    localparam logic [4:0] S_INS_DL   = 5'd16;
    localparam logic [4:0] S_INS_CHK  = 5'd17;
    localparam logic [4:0] S_INS_END  = 5'd18;
    localparam logic [4:0] S_INS_TAIL = 5'd19;

    logic [4:0] state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    // Advance state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.rk_ld  = 1'b1;
                cmd.rk_val = sdtp_pkg::RK_ACK;
                state_next = S_ACK;
                case (stat.kind)
                    sdtp_pkg::KIND_TICK: begin
                        cmd.rk_ld  = 1'b0;
                        cmd.tick   = 1'b1;
                        state_next = S_TCHK;
                    end
                    sdtp_pkg::KIND_ALLOC: begin
                        cmd.ptr_clr = 1'b1;
                        state_next  = S_SCAN;
                    end
                    sdtp_pkg::KIND_FREE: begin
                        if (stat.inpool && !stat.slot_zero) begin
                            cmd.st_wr  = 1'b1;
                            cmd.st_val = sdtp_pkg::ST_FREE;
                            if (stat.st_active) begin
                                state_next = S_UNL_ST;
                            end
                        end
                    end
                    sdtp_pkg::KIND_INIT: begin
                        cmd.init_wr = stat.inpool && !stat.slot_zero;
                    end
                    sdtp_pkg::KIND_SET: begin
                        if (stat.inpool) begin
                            if (stat.slot_zero || stat.st_active) begin
                                cmd.rk_val = sdtp_pkg::RK_ACTIVE;
                            end else begin
                                cmd.st_wr  = 1'b1;
                                cmd.st_val = sdtp_pkg::ST_ACTIVE;
                                cmd.set_dl = 1'b1;
                                state_next = S_INS_ST;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            S_ACK: begin
                if (stat.out_free) begin
                    cmd.emit_ack = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            // Expiry: pop due entries off the head
            S_TCHK: begin
                state_next = (!stat.head_zero && stat.due) ? S_POP_RD : S_IDLE;
            end
            S_POP_RD: begin
                cmd.nx_rd  = 1'b1;
                cmd.nx_ra  = sdtp_pkg::RA_HEAD;
                cmd.pd_rd  = 1'b1;
                state_next = S_POP_NX;
            end
            S_POP_NX: begin
                cmd.dl_rd  = 1'b1;
                state_next = S_POP_EM;
            end
            S_POP_EM: begin
                if (stat.out_free) begin
                    cmd.emit_pop = 1'b1;
                    cmd.head_sel = sdtp_pkg::H_NXQ;
                    cmd.earl_sel = sdtp_pkg::E_DLQ;
                    state_next   = stat.pop_last ? S_IDLE : S_POP_RD;
                end
            end
            // Allocate: scan for the first free slot
            S_SCAN: begin
                if (stat.st_free) begin
                    cmd.st_wr     = 1'b1;
                    cmd.st_val    = sdtp_pkg::ST_ALLOC;
                    cmd.rk_ld     = 1'b1;
                    cmd.rk_val    = sdtp_pkg::RK_ACK;
                    cmd.rslot_ptr = 1'b1;
                    state_next    = S_ACK;
                end else if (stat.ptr_last) begin
                    cmd.rk_ld  = 1'b1;
                    cmd.rk_val = sdtp_pkg::RK_NOFREE;
                    state_next = S_ACK;
                end else begin
                    cmd.ptr_inc = 1'b1;
                end
            end
            // Free: unlink an active slot
            S_UNL_ST: begin
                if (stat.head_is_slot) begin
                    cmd.nx_rd  = 1'b1;
                    cmd.nx_ra  = sdtp_pkg::RA_SLOT;
                    state_next = S_UNL_H1;
                end else begin
                    cmd.prev_sel = sdtp_pkg::P_HEAD;
                    cmd.cnt_clr  = 1'b1;
                    state_next   = S_UNL_RD;
                end
            end
            S_UNL_H1: begin
                cmd.dl_rd  = 1'b1;
                state_next = S_UNL_H2;
            end
            S_UNL_H2: begin
                cmd.head_sel = sdtp_pkg::H_NXQ;
                cmd.earl_sel = sdtp_pkg::E_DLQ;
                state_next   = S_ACK;
            end
            S_UNL_RD: begin
                cmd.nx_rd  = 1'b1;
                cmd.nx_ra  = sdtp_pkg::RA_PREV;
                state_next = S_UNL_CHK;
            end
            S_UNL_CHK: begin
                if (stat.nx_is_slot) begin
                    cmd.nx_rd  = 1'b1;
                    cmd.nx_ra  = sdtp_pkg::RA_SLOT;
                    state_next = S_UNL_LINK;
                end else if (stat.nx_zero) begin
                    state_next = S_ACK;
                end else begin
                    cmd.prev_sel = sdtp_pkg::P_NXQ;
                    cmd.cnt_inc  = 1'b1;
                    state_next   = stat.cnt_last ? S_ACK : S_UNL_RD;
                end
            end
            S_UNL_LINK: begin
                cmd.nx_wr  = 1'b1;
                cmd.nx_wa  = sdtp_pkg::WA_PREV;
                cmd.nx_wd  = sdtp_pkg::WD_NXQ;
                state_next = S_ACK;
            end
            // Set: insert ahead of equal deadlines
            S_INS_ST: begin
                if (stat.dl_le_earl) begin
                    cmd.nx_wr    = 1'b1;
                    cmd.nx_wa    = sdtp_pkg::WA_SLOT;
                    cmd.nx_wd    = sdtp_pkg::WD_HEAD;
                    cmd.head_sel = sdtp_pkg::H_SLOT;
                    cmd.earl_sel = sdtp_pkg::E_DL;
                    state_next   = S_ACK;
                end else begin
                    cmd.prev_sel = sdtp_pkg::P_HEAD;
                    cmd.cnt_clr  = 1'b1;
                    state_next   = S_INS_RD;
                end
            end
            S_INS_RD: begin
                cmd.nx_rd  = 1'b1;
                cmd.nx_ra  = sdtp_pkg::RA_PREV;
                state_next = S_INS_DL;
            end
            S_INS_DL: begin
                cmd.cur_ld = 1'b1;
                cmd.dl_rd  = 1'b1;
                state_next = S_INS_CHK;
            end
            S_INS_CHK: begin
                if (stat.dl_le_q || stat.cur_zero) begin
                    cmd.nx_wr  = 1'b1;
                    cmd.nx_wa  = sdtp_pkg::WA_PREV;
                    cmd.nx_wd  = sdtp_pkg::WD_SLOT;
                    state_next = S_INS_TAIL;
                end else begin
                    cmd.prev_sel = sdtp_pkg::P_CUR;
                    cmd.cnt_inc  = 1'b1;
                    state_next   = stat.cnt_last ? S_INS_END : S_INS_RD;
                end
            end
            S_INS_END: begin
                cmd.nx_wr   = 1'b1;
                cmd.nx_wa   = sdtp_pkg::WA_PREV;
                cmd.nx_wd   = sdtp_pkg::WD_SLOT;
                cmd.cur_clr = 1'b1;
                state_next  = S_INS_TAIL;
            end
            S_INS_TAIL: begin
                cmd.nx_wr  = 1'b1;
                cmd.nx_wa  = sdtp_pkg::WA_SLOT;
                cmd.nx_wd  = sdtp_pkg::WD_CUR;
                state_next = S_ACK;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* hdl/sdtp_dp.sv */
// Datapath of the timer pool: pointers, status flags, link/deadline/payload
// RAMs and the result register. Depends on sdtp_pkg and sdtp_ram.
`default_nettype none
module sdtp_dp #(
    parameter int TIMER_SLOTS = sdtp_pkg::TIMER_SLOTS_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_we,
    input  wire logic [4:0]      cfg_wdata,
    input  wire logic [79:0]     s_tdata,
    input  wire logic [2:0]      s_tuser,
    input  wire logic            m_tready,
    output logic                 m_tvalid,
    output logic [47:0]          m_tdata,
    output logic [2:0]           m_tuser,
    output logic                 m_tlast,
    input  wire sdtp_pkg::cmd_t  cmd,
    output sdtp_pkg::stat_t      stat
);

    localparam int SW = $clog2(TIMER_SLOTS);
    localparam int CW = (SW > 5) ? SW : 5;
    localparam logic [6:0]    NPOOL     = 7'(TIMER_SLOTS);
    localparam logic [SW-1:0] LAST_SLOT = SW'(TIMER_SLOTS - 1);
    localparam logic [4:0]    LAST_RES  = 5'(sdtp_pkg::MAX_RES - 1);

    logic [31:0]   now_reg, earl_reg, dl_reg, delay_reg, pay_in_reg;
    logic [7:0]    dest_in_reg;
    logic [2:0]    kind_reg;
    logic [4:0]    slot_in_reg, tss_reg, k_reg;
    logic [SW-1:0] head_reg, ptr_reg, prev_reg, cur_reg, cnt_reg;
    logic [1:0]    st_reg [TIMER_SLOTS];
    logic          dlz_reg;
    logic [1:0]    rk_reg;
    logic [4:0]    rslot_reg;
    logic          ovalid_reg, olast_reg;
    logic [1:0]    okind_reg;
    logic [4:0]    oslot_reg;
    logic [31:0]   opay_reg;
    logic [7:0]    odest_reg;
    logic          ots_reg;

    logic [SW-1:0] nx_q, nx_raddr, nx_waddr, nx_wdata;
    logic [31:0]   dl_q, dlq, dl_sum;
    logic [39:0]   pd_q;
    logic [1:0]    st_ptr;
    logic          ts_hit;

    assign dl_sum = now_reg + delay_reg;
    assign dlq    = dlz_reg ? 32'hffff_ffff : dl_q;
    assign st_ptr = st_reg[ptr_reg];
    assign ts_hit = (tss_reg != 5'd0) && (CW'(head_reg) == CW'(tss_reg));

    // Link RAM address and data selection
    always_comb begin
        case (cmd.nx_ra)
            sdtp_pkg::RA_HEAD: nx_raddr = head_reg;
            sdtp_pkg::RA_SLOT: nx_raddr = ptr_reg;
            default:           nx_raddr = prev_reg;
        endcase
        nx_waddr = (cmd.nx_wa == sdtp_pkg::WA_PREV) ? prev_reg : ptr_reg;
        case (cmd.nx_wd)
            sdtp_pkg::WD_HEAD: nx_wdata = head_reg;
            sdtp_pkg::WD_SLOT: nx_wdata = ptr_reg;
            sdtp_pkg::WD_CUR:  nx_wdata = cur_reg;
            default:           nx_wdata = nx_q;
        endcase
    end

    sdtp_ram #(.WIDTH(SW), .DEPTH(TIMER_SLOTS)) u_next (
        .aclk    (aclk),
        .wr_en   (cmd.nx_wr),
        .wr_addr (nx_waddr),
        .wr_data (nx_wdata),
        .rd_en   (cmd.nx_rd),
        .rd_addr (nx_raddr),
        .rd_data (nx_q)
    );

    sdtp_ram #(.WIDTH(32), .DEPTH(TIMER_SLOTS)) u_deadline (
        .aclk    (aclk),
        .wr_en   (cmd.set_dl),
        .wr_addr (ptr_reg),
        .wr_data (dl_sum),
        .rd_en   (cmd.dl_rd),
        .rd_addr (nx_q),
        .rd_data (dl_q)
    );

    sdtp_ram #(.WIDTH(40), .DEPTH(TIMER_SLOTS)) u_payload (
        .aclk    (aclk),
        .wr_en   (cmd.init_wr),
        .wr_addr (ptr_reg),
        .wr_data ({dest_in_reg, pay_in_reg}),
        .rd_en   (cmd.pd_rd),
        .rd_addr (head_reg),
        .rd_data (pd_q)
    );

    // Status back to the controller
    always_comb begin
        stat.kind         = kind_reg;
        stat.inpool       = {2'b00, slot_in_reg} < NPOOL;
        stat.slot_zero    = (slot_in_reg == 5'd0);
        stat.st_free      = (st_ptr == sdtp_pkg::ST_FREE);
        stat.st_active    = (st_ptr == sdtp_pkg::ST_ACTIVE);
        stat.ptr_last     = (ptr_reg == LAST_SLOT);
        stat.head_zero    = (head_reg == '0);
        stat.due          = (earl_reg <= now_reg);
        stat.head_is_slot = (head_reg == ptr_reg);
        stat.nx_is_slot   = (nx_q == ptr_reg);
        stat.nx_zero      = (nx_q == '0);
        stat.cnt_last     = (cnt_reg == LAST_SLOT);
        stat.dl_le_earl   = (dl_reg <= earl_reg);
        stat.dl_le_q      = (dl_reg <= dlq);
        stat.cur_zero     = (cur_reg == '0);
        stat.out_free     = !ovalid_reg || m_tready;
        stat.pop_last     = (k_reg == LAST_RES) || (nx_q == '0) || (dlq > now_reg);
    end

    // Control state: time base, list head, earliest deadline, switch slot, status flags, result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg    <= '0;
            earl_reg   <= 32'hffff_ffff;
            head_reg   <= '0;
            tss_reg    <= '0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < TIMER_SLOTS; i++) begin
                st_reg[i] <= (i == 0) ? sdtp_pkg::ST_ACTIVE : sdtp_pkg::ST_FREE;
            end
        end else begin
            if (cfg_we) begin
                tss_reg <= cfg_wdata;
            end
            if (cmd.tick) begin
                now_reg <= now_reg + 32'd1;
            end
            case (cmd.head_sel)
                sdtp_pkg::H_NXQ:  head_reg <= nx_q;
                sdtp_pkg::H_SLOT: head_reg <= ptr_reg;
                default: ;
            endcase
            case (cmd.earl_sel)
                sdtp_pkg::E_DLQ: earl_reg <= dlq;
                sdtp_pkg::E_DL:  earl_reg <= dl_reg;
                default: ;
            endcase
            if (cmd.st_wr) begin
                st_reg[ptr_reg] <= cmd.st_val;
            end
            if (cmd.emit_pop) begin
                st_reg[head_reg] <= sdtp_pkg::ST_ALLOC;
            end
            if (cmd.emit_ack || cmd.emit_pop) begin
                ovalid_reg <= 1'b1;
            end else if (m_tready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // Working registers of the walk and the captured item
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg    <= s_tuser;
            slot_in_reg <= s_tdata[4:0];
            delay_reg   <= s_tdata[36:5];
            pay_in_reg  <= s_tdata[68:37];
            dest_in_reg <= s_tdata[76:69];
            ptr_reg     <= SW'(s_tdata[4:0]);
            k_reg       <= '0;
        end else if (cmd.ptr_clr) begin
            ptr_reg <= '0;
        end else if (cmd.ptr_inc) begin
            ptr_reg <= ptr_reg + SW'(1);
        end
        if (cmd.emit_pop) begin
            k_reg <= k_reg + 5'd1;
        end
        if (cmd.set_dl) begin
            dl_reg <= dl_sum;
        end
        if (cmd.dl_rd) begin
            dlz_reg <= (nx_q == '0);
        end
        case (cmd.prev_sel)
            sdtp_pkg::P_HEAD: prev_reg <= head_reg;
            sdtp_pkg::P_NXQ:  prev_reg <= nx_q;
            sdtp_pkg::P_CUR:  prev_reg <= cur_reg;
            default: ;
        endcase
        if (cmd.cur_clr) begin
            cur_reg <= '0;
        end else if (cmd.cur_ld) begin
            cur_reg <= nx_q;
        end
        if (cmd.cnt_clr) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_inc) begin
            cnt_reg <= cnt_reg + SW'(1);
        end
        if (cmd.rk_ld) begin
            rk_reg    <= cmd.rk_val;
            rslot_reg <= cmd.rslot_ptr ? 5'(ptr_reg) : 5'd0;
        end
        // Load the result register
        if (cmd.emit_ack) begin
            okind_reg <= rk_reg;
            oslot_reg <= rslot_reg;
            opay_reg  <= '0;
            odest_reg <= '0;
            ots_reg   <= 1'b0;
            olast_reg <= 1'b1;
        end else if (cmd.emit_pop) begin
            okind_reg <= sdtp_pkg::RK_EXPIRY;
            oslot_reg <= 5'(head_reg);
            opay_reg  <= ts_hit ? 32'd0 : pd_q[31:0];
            odest_reg <= ts_hit ? 8'd0 : pd_q[39:32];
            ots_reg   <= ts_hit;
            olast_reg <= stat.pop_last;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {3'b000, odest_reg, opay_reg, oslot_reg};
    assign m_tuser  = {ots_reg, okind_reg};
    assign m_tlast  = olast_reg;

endmodule
`default_nettype wire
